FILE: rtl/omd_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and helpers for the pulse decoder
package omd_pkg;

  // byte store geometry
  localparam int BufferBytes = 16;
  localparam int AddrW       = $clog2(BufferBytes);

  // field widths
  localparam int WidthW = 16;
  localparam int CountW = 7;
  localparam int IdxW   = 4;
  localparam int ByteW  = 8;
  localparam int PreW   = 8;

  // register reset values
  localparam logic [WidthW-1:0] MinWidthRst    = 16'd200;
  localparam logic [WidthW-1:0] LongWidthRst   = 16'd700;
  localparam logic [WidthW-1:0] MaxWidthRst    = 16'd1200;
  localparam logic [PreW-1:0]   PreambleMinRst = 8'd32;

  // bit count landmarks
  localparam logic [CountW-1:0] SkipBits  = 7'd4;
  localparam logic [CountW-1:0] FullBits  = 7'd80;
  localparam logic [CountW-1:0] GapLoBits = 7'd40;
  localparam logic [CountW-1:0] GapHiBits = 7'd104;
  localparam logic [IdxW-1:0]   MaxOut    = 4'd9;
  localparam logic [PreW-1:0]   PreSat    = 8'hFF;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_MIN_WIDTH    = 2'd0,
    CFG_LONG_WIDTH   = 2'd1,
    CFG_MAX_WIDTH    = 2'd2,
    CFG_PREAMBLE_MIN = 2'd3
  } cfg_reg_e;

  // decoder phase
  typedef enum logic [3:0] {
    PH_HUNT  = 4'b0001,
    PH_LEVEL = 4'b0010,
    PH_HALF  = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [WidthW-1:0] min_width;
    logic [WidthW-1:0] long_width;
    logic [WidthW-1:0] max_width;
    logic [PreW-1:0]   preamble_min;
  } cfg_t;

  typedef struct packed {
    logic             rd_en;
    logic [AddrW-1:0] rd_addr;
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    logic [ByteW-1:0] wr_data;
    logic             clear;
  } mem_req_t;

  typedef struct packed {
    phase_e            phase;
    logic [CountW-1:0] bit_cnt;
    logic              emitting;
  } status_t;

  // whole bytes held for a given bit count
  function automatic logic [IdxW-1:0] whole_bytes(input logic [CountW-1:0] cnt);
    logic [CountW-1:0] done_bits;
    done_bits = cnt - SkipBits;
    return (cnt < SkipBits) ? '0 : done_bits[CountW-1:3];
  endfunction

endpackage

FILE: rtl/omd_if.sv
`timescale 1ns / 1ps
// channel interfaces: pulse input, byte output, configuration writes
interface omd_in_if;
  import omd_pkg::*;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [WidthW-1:0] pulse_width;
  modport source (output valid, output cmd, output pulse_width, input ready);
  modport sink   (input valid, input cmd, input pulse_width, output ready);
endinterface

interface omd_out_if;
  import omd_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic [IdxW-1:0]  byte_index;
  logic             last;
  modport source (output valid, output data_byte, output byte_index, output last,
                  input ready);
  modport sink   (input valid, input data_byte, input byte_index, input last,
                  output ready);
endinterface

interface omd_cfg_if;
  import omd_pkg::*;
  logic              valid;
  logic              ready;
  cfg_reg_e          index;
  logic [WidthW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/omd_store.sv
`timescale 1ns / 1ps
// message byte store: synchronous ram with per-entry valid bits
module omd_store (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  omd_pkg::mem_req_t       req_i,
  output logic [omd_pkg::ByteW-1:0] rd_data_o
);
  import omd_pkg::*;

  logic [ByteW-1:0]       mem_q [BufferBytes];
  logic [BufferBytes-1:0] valid_q;
  logic [ByteW-1:0]       rd_raw_q;
  logic                   rd_valid_q;

  // ram array, registered read
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_raw_q <= mem_q[req_i.rd_addr];
    end
  end

  // entry valid bits, cleared at once on restart or error
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.clear) begin
        valid_q <= '0;
      end else if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= valid_q[req_i.rd_addr];
      end
    end
  end

  // unwritten entries read as zero
  assign rd_data_o = rd_valid_q ? rd_raw_q : '0;

endmodule

FILE: rtl/omd_ctrl.sv
`timescale 1ns / 1ps
// pulse classifier, symbol decoder and byte run sequencer
module omd_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  omd_pkg::cfg_t           cfg_i,
  omd_in_if.sink                  in_i,
  omd_out_if.source               out_o,
  output omd_pkg::mem_req_t       mem_req_o,
  input  logic [omd_pkg::ByteW-1:0] rd_data_i,
  output omd_pkg::status_t        status_o
);
  import omd_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DECIDE = 5'b00010,
    ST_RMW    = 5'b00100,
    ST_RD     = 5'b01000,
    ST_LOAD   = 5'b10000
  } ctrl_state_e;

  ctrl_state_e       state_q, state_d;
  phase_e            phase_q, phase_d;
  logic [PreW-1:0]   pol_q, pol_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              cmd_q, cmd_d;
  logic [WidthW-1:0] width_q, width_d;
  logic              lvl_q, lvl_d;
  logic [IdxW-1:0]   n_q, n_d;
  logic [IdxW-1:0]   k_q, k_d;
  logic              out_valid_q, out_valid_d;
  logic [ByteW-1:0]  out_byte_q, out_byte_d;
  logic [IdxW-1:0]   out_idx_q, out_idx_d;
  logic              out_last_q, out_last_d;

  logic              is_sym, is_long, gap_ok;
  logic              take_bit, new_lvl, clear, complete;
  logic [CountW-1:0] cnt_inc, done_bits, done_cnt;
  logic [IdxW-1:0]   n_raw;
  logic [AddrW-1:0]  byte_addr;
  logic [ByteW-1:0]  shifted;
  logic              k_last;

  // pulse classes against the thresholds
  assign is_sym  = (width_q >= cfg_i.min_width) && (width_q < cfg_i.max_width);
  assign is_long = (width_q >= cfg_i.long_width);
  assign gap_ok  = (cnt_q >= GapLoBits) && (cnt_q < GapHiBits);

  // store address of the byte being filled
  assign byte_addr = AddrW'(whole_bytes(cnt_q));
  assign cnt_inc   = cnt_q + 7'd1;
  assign done_bits = cnt_inc - SkipBits;
  assign shifted   = {lvl_q, rd_data_i[ByteW-1:1]};
  assign k_last    = (k_q == (n_q - 4'd1));

  // next state
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    pol_d       = pol_q;
    cnt_d       = cnt_q;
    cmd_d       = cmd_q;
    width_d     = width_q;
    lvl_d       = lvl_q;
    n_d         = n_q;
    k_d         = k_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_idx_d   = out_idx_q;
    out_last_d  = out_last_q;
    mem_req_o   = '0;
    take_bit    = 1'b0;
    new_lvl     = 1'b0;
    clear       = 1'b0;
    complete    = 1'b0;
    done_cnt    = cnt_q;
    n_raw       = '0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          cmd_d   = in_i.cmd;
          width_d = in_i.pulse_width;
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_d = ST_IDLE;
        if (cmd_q) begin
          clear = 1'b1;
        end else if (phase_q == PH_DONE) begin
          // pulses are ignored until a restart
        end else if (!is_sym) begin
          // gap: ends the message inside the bit window, else error
          if (gap_ok) begin
            complete = 1'b1;
          end else begin
            clear = 1'b1;
          end
        end else if (!is_long) begin
          if (phase_q == PH_HUNT) begin
            if (pol_q != PreSat) begin
              pol_d = pol_q + 8'd1;
            end
          end else if (phase_q == PH_LEVEL) begin
            phase_d = PH_HALF;
          end else begin
            take_bit = 1'b1;
            new_lvl  = pol_q[0];
          end
        end else begin
          if (phase_q == PH_HUNT) begin
            if (pol_q >= cfg_i.preamble_min) begin
              take_bit = 1'b1;
              new_lvl  = 1'b0;
            end else begin
              clear = 1'b1;
            end
          end else if (phase_q == PH_LEVEL) begin
            take_bit = 1'b1;
            new_lvl  = ~pol_q[0];
          end else begin
            clear = 1'b1;
          end
        end
        // a bit: the first few are only counted, the rest go to the store
        if (take_bit) begin
          pol_d   = {{(PreW-1){1'b0}}, new_lvl};
          phase_d = PH_LEVEL;
          if (cnt_q < SkipBits) begin
            cnt_d = cnt_inc;
          end else begin
            mem_req_o.rd_en   = 1'b1;
            mem_req_o.rd_addr = byte_addr;
            lvl_d             = new_lvl;
            state_d           = ST_RMW;
          end
        end
      end
      ST_RMW: begin
        // shift the bit in from the top, swap nibbles on a full byte
        mem_req_o.wr_en   = 1'b1;
        mem_req_o.wr_addr = byte_addr;
        mem_req_o.wr_data = (done_bits[2:0] == 3'd0) ?
                            {shifted[3:0], shifted[7:4]} : shifted;
        cnt_d    = cnt_inc;
        done_cnt = cnt_inc;
        state_d  = ST_IDLE;
        if (cnt_inc == FullBits) begin
          complete = 1'b1;
        end
      end
      ST_RD: begin
        mem_req_o.rd_en   = 1'b1;
        mem_req_o.rd_addr = AddrW'(k_q);
        state_d           = ST_LOAD;
      end
      ST_LOAD: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_byte_d  = rd_data_i;
          out_idx_d   = k_q;
          out_last_d  = k_last;
          if (k_last) begin
            state_d = ST_IDLE;
          end else begin
            k_d     = k_q + 4'd1;
            state_d = ST_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // error or restart wipes decoder and store
    if (clear) begin
      phase_d         = PH_HUNT;
      pol_d           = '0;
      cnt_d           = '0;
      mem_req_o.clear = 1'b1;
    end

    // completion starts the byte run
    if (complete) begin
      phase_d = PH_DONE;
      n_raw   = whole_bytes(done_cnt);
      n_d     = (n_raw > MaxOut) ? MaxOut : n_raw;
      k_d     = '0;
      if (n_raw != '0) begin
        state_d = ST_RD;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_HUNT;
      pol_q       <= '0;
      cnt_q       <= '0;
      n_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      pol_q       <= pol_d;
      cnt_q       <= cnt_d;
      n_q         <= n_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    width_q    <= width_d;
    lvl_q      <= lvl_d;
    out_byte_q <= out_byte_d;
    out_idx_q  <= out_idx_d;
    out_last_q <= out_last_d;
  end

  // channel outputs
  assign in_i.ready       = (state_q == ST_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.data_byte  = out_byte_q;
  assign out_o.byte_index = out_idx_q;
  assign out_o.last       = out_last_q;

  assign status_o.phase    = phase_q;
  assign status_o.bit_cnt  = cnt_q;
  assign status_o.emitting = (state_q == ST_RD) || (state_q == ST_LOAD);

endmodule

FILE: rtl/ook_manchester_pulse_decoder.sv
`timescale 1ns / 1ps
// top level of the ook manchester pulse width decoder
//
// in_i carries one word per pulse: pulse_width, or cmd = 1 to restart the
// decoder and wipe the byte store. out_o carries the decoded message bytes
// (data_byte, byte_index, last), one word per byte, in order from index 0.
// cfg_i writes the four threshold registers; it is always ready and should
// only be used while the decoder is idle.
// A pulse that adds no stored bit passes through the decide state only; one
// that does also takes the read-modify-write of one byte in the store ram
// (one read then one write per bit).
// When a message completes, the run of up to 9 bytes is read from the ram
// byte by byte, each read then loaded into the output register; no pulse is
// accepted until the last byte of the run sits in the output register.
// The output register holds a word until the receiver takes it; the run
// stalls behind it, while a finished run lets new pulses in.
// Reset puts the registers at their defaults, the decoder in preamble hunt
// and marks every store entry empty at once, so no clearing pass runs.
module ook_manchester_pulse_decoder (
  input  logic      clk_i,
  input  logic      rst_ni,
  omd_in_if.sink    in_i,
  omd_out_if.source out_o,
  omd_cfg_if.sink   cfg_i
);
  import omd_pkg::*;

  cfg_t     cfg_q;
  mem_req_t mem_req;
  logic [ByteW-1:0] rd_data;
  status_t  status;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_width    <= MinWidthRst;
      cfg_q.long_width   <= LongWidthRst;
      cfg_q.max_width    <= MaxWidthRst;
      cfg_q.preamble_min <= PreambleMinRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_MIN_WIDTH:    cfg_q.min_width    <= cfg_i.data;
        CFG_LONG_WIDTH:   cfg_q.long_width   <= cfg_i.data;
        CFG_MAX_WIDTH:    cfg_q.max_width    <= cfg_i.data;
        CFG_PREAMBLE_MIN: cfg_q.preamble_min <= cfg_i.data[PreW-1:0];
        default: begin
        end
      endcase
    end
  end

  // decoder control
  omd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .in_i      (in_i),
    .out_o     (out_o),
    .mem_req_o (mem_req),
    .rd_data_i (rd_data),
    .status_o  (status)
  );

  // byte store
  omd_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  // a message never runs past the full bit count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.bit_cnt <= FullBits)
    else $error("bit count beyond full message");

  // the byte run only happens after completion
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.emitting |-> status.phase == PH_DONE)
    else $error("byte run outside done phase");

  // a restart leaves the decoder hunting with no bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.cmd) |=> ##1
      (status.phase == PH_HUNT && status.bit_cnt == '0))
    else $error("restart did not clear decoder");

  // pulses while done are ignored
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && !in_i.cmd && status.phase == PH_DONE) |=> ##1
      (status.phase == PH_DONE))
    else $error("pulse left done phase");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// self-checking bench for the ook manchester pulse decoder: random pulse trains vs a local model
module testbench;
  import omd_pkg::*;

  localparam int SettleCycles   = 40;
  localparam int PressureCycles = 400;
  localparam int ItemCap        = 700;
  localparam int CycleLimit     = 600000;
  localparam int BytesWanted    = 54;

  typedef struct packed {
    logic              cmd;
    logic [WidthW-1:0] width;
  } pulse_word_t;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic [IdxW-1:0]  idx;
    logic             last;
  } msg_byte_t;

  typedef enum int {
    MSG_FULL,
    MSG_GAP_END,
    MSG_EARLY_GAP,
    MSG_SHORT_LONG,
    MSG_SHORT_PREAMBLE
  } msg_kind_e;

  logic clk_i;
  logic rst_ni = 1'b0;

  // testbench-owned drive values, known from time zero
  logic              in_valid  = 1'b0;
  pulse_word_t       in_word   = '0;
  logic              out_ready = 1'b0;
  logic              cfg_valid = 1'b0;
  cfg_reg_e          cfg_index = CFG_MIN_WIDTH;
  logic [WidthW-1:0] cfg_data  = '0;

  omd_in_if  in_if ();
  omd_out_if out_if ();
  omd_cfg_if cfg_if ();

  assign in_if.valid        = in_valid;
  assign in_if.cmd          = in_word.cmd;
  assign in_if.pulse_width  = in_word.width;
  assign out_if.ready       = out_ready;
  assign cfg_if.valid       = cfg_valid;
  assign cfg_if.index       = cfg_index;
  assign cfg_if.data        = cfg_data;

  ook_manchester_pulse_decoder uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // pulse words waiting to be sent, message bytes waiting to be seen
  pulse_word_t pending_pulses[$];
  msg_byte_t   expected_bytes[$];

  int errors          = 0;
  int pulses_queued   = 0;
  int pulses_sent     = 0;
  int results_seen    = 0;
  int bytes_predicted = 0;
  int messages_done   = 0;
  int cfg_phases      = 1;

  // decoder model state and its copy of the thresholds
  cfg_t             model_cfg = '{MinWidthRst, LongWidthRst, MaxWidthRst, PreambleMinRst};
  phase_e           dec_phase;
  logic [PreW-1:0]  dec_level;
  int               dec_bits;
  logic [ByteW-1:0] dec_store [BufferBytes];

  // clock and reset
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // decoder model

  function automatic int held_bytes(input int bits);
    return (bits < SkipBits) ? 0 : (bits - SkipBits) >> 3;
  endfunction

  function automatic void clear_decoder_model();
    dec_phase = PH_HUNT;
    dec_level = '0;
    dec_bits  = 0;
    foreach (dec_store[i]) dec_store[i] = '0;
  endfunction

  // one received bit: skip the first few, else shift in from the top
  function automatic void shift_bit(input logic lvl);
    int idx;
    int done_bits;
    if (dec_bits < SkipBits) begin
      dec_bits++;
      dec_phase = PH_LEVEL;
      return;
    end
    idx = held_bytes(dec_bits);
    if (idx < BufferBytes) dec_store[idx] = {lvl, dec_store[idx][ByteW-1:1]};
    dec_bits  = (dec_bits + 1) & 127;
    done_bits = dec_bits - SkipBits;
    idx       = done_bits >> 3;
    // completed byte gets its nibbles swapped
    if ((done_bits & 7) == 0 && idx >= 1 && idx - 1 < BufferBytes)
      dec_store[idx-1] = {dec_store[idx-1][3:0], dec_store[idx-1][7:4]};
    if (idx >= BufferBytes) begin
      clear_decoder_model();
      return;
    end
    dec_phase = PH_LEVEL;
  endfunction

  function automatic void data_symbol(input logic toggle);
    dec_level = {7'd0, dec_level[0] ^ toggle};
    shift_bit(dec_level[0]);
  endfunction

  // -1 error, 1 message complete, 0 keep going
  function automatic int sort_pulse(input logic [WidthW-1:0] w);
    logic is_long;
    if (w >= model_cfg.min_width && w < model_cfg.max_width) begin
      is_long = (w >= model_cfg.long_width);
      case (dec_phase)
        PH_HUNT: begin
          if (!is_long) begin
            if (dec_level != PreSat) dec_level++;
          end else if (dec_level >= model_cfg.preamble_min) begin
            dec_level = 8'd1;
            data_symbol(1'b1);
          end else begin
            return -1;
          end
        end
        PH_LEVEL: begin
          if (!is_long) dec_phase = PH_HALF;
          else data_symbol(1'b1);
        end
        default: begin
          if (!is_long) data_symbol(1'b0);
          else return -1;
        end
      endcase
      return (dec_bits == FullBits) ? 1 : 0;
    end
    return (dec_bits >= GapLoBits && dec_bits < GapHiBits) ? 1 : -1;
  endfunction

  // apply one accepted pulse word, queue the bytes of a finished message
  function automatic void decode_pulse(input pulse_word_t p);
    int        verdict;
    int        n;
    int        k;
    msg_byte_t b;
    if (p.cmd) begin
      clear_decoder_model();
      return;
    end
    if (dec_phase == PH_DONE) return;
    verdict = sort_pulse(p.width);
    if (verdict < 0) begin
      clear_decoder_model();
      return;
    end
    if (verdict == 0) return;
    dec_phase = PH_DONE;
    n = held_bytes(dec_bits);
    if (n > MaxOut) n = MaxOut;
    if (n > BufferBytes) n = BufferBytes;
    for (k = 0; k < n; k++) begin
      b.data = dec_store[k];
      b.idx  = IdxW'(k);
      b.last = (k + 1 == n);
      expected_bytes.push_back(b);
    end
    bytes_predicted += n;
    if (n > 0) messages_done++;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers

  function automatic logic can_short();
    return model_cfg.min_width < model_cfg.max_width &&
           model_cfg.min_width < model_cfg.long_width;
  endfunction

  function automatic logic can_long();
    int lo;
    lo = (model_cfg.long_width > model_cfg.min_width) ? model_cfg.long_width
                                                        : model_cfg.min_width;
    return lo < model_cfg.max_width;
  endfunction

  // value in [lo, hi], with the ends favored
  function automatic logic [WidthW-1:0] width_between(input int lo, input int hi);
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return WidthW'(lo);
    if (r == 1) return WidthW'(hi);
    return WidthW'($urandom_range(hi, lo));
  endfunction

  function automatic logic [WidthW-1:0] short_width();
    int hi;
    hi = (model_cfg.long_width < model_cfg.max_width) ? model_cfg.long_width
                                                        : model_cfg.max_width;
    return width_between(model_cfg.min_width, hi - 1);
  endfunction

  function automatic logic [WidthW-1:0] long_width();
    int lo;
    lo = (model_cfg.long_width > model_cfg.min_width) ? model_cfg.long_width
                                                        : model_cfg.min_width;
    return width_between(lo, model_cfg.max_width - 1);
  endfunction

  function automatic logic [WidthW-1:0] gap_width();
    if (model_cfg.min_width != 0 && $urandom_range(0, 1))
      return width_between(0, model_cfg.min_width - 1);
    return width_between(model_cfg.max_width, 16'hFFFF);
  endfunction

  task automatic push_pulse(input logic c, input logic [WidthW-1:0] w);
    pulse_word_t p;
    p.cmd   = c;
    p.width = w;
    pending_pulses.push_back(p);
    pulses_queued++;
  endtask

  // restarts, raw widths and widths of each class
  task automatic add_noise(input int count);
    int r;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 10) push_pulse(1'b1, 16'($urandom));
      else if (r < 45) push_pulse(1'b0, 16'($urandom));
      else if (r < 65 && can_short()) push_pulse(1'b0, short_width());
      else if (r < 85 && can_long()) push_pulse(1'b0, long_width());
      else push_pulse(1'b0, gap_width());
    end
  endtask

  // restart, preamble, start pulse, manchester data and an ending
  task automatic add_message();
    msg_kind_e kind;
    int        pre;
    int        nbits;
    int        cut;
    int        i;
    int        r;
    logic      lvl;
    logic      b;
    if (!can_long()) begin
      add_noise(8);
      return;
    end
    if ($urandom_range(0, 99) < 85) push_pulse(1'b1, 16'($urandom));
    r = $urandom_range(0, 99);
    if (r < 40) kind = MSG_FULL;
    else if (r < 65) kind = MSG_GAP_END;
    else if (r < 77) kind = MSG_EARLY_GAP;
    else if (r < 89) kind = MSG_SHORT_LONG;
    else kind = MSG_SHORT_PREAMBLE;
    if (kind == MSG_SHORT_LONG && !can_short()) kind = MSG_FULL;
    if (kind == MSG_SHORT_PREAMBLE && model_cfg.preamble_min == 0) kind = MSG_GAP_END;

    // preamble, past the saturation point when the minimum is at its top
    pre = model_cfg.preamble_min + $urandom_range(0, 3);
    if (model_cfg.preamble_min == PreSat) pre += 2;
    if (kind == MSG_SHORT_PREAMBLE) pre = $urandom_range(0, model_cfg.preamble_min - 1);
    if (!can_short()) pre = 0;
    repeat (pre) push_pulse(1'b0, short_width());
    push_pulse(1'b0, long_width());
    if (kind == MSG_SHORT_PREAMBLE) return;

    case (kind)
      MSG_GAP_END:   nbits = $urandom_range(GapLoBits, FullBits - 1);
      MSG_EARLY_GAP: nbits = $urandom_range(1, GapLoBits - 1);
      default:       nbits = FullBits;
    endcase
    cut = (kind == MSG_SHORT_LONG) ? $urandom_range(2, FullBits) : 0;

    // start bit sits at level zero; long toggles, short pair repeats
    lvl = 1'b0;
    for (i = 2; i <= nbits; i++) begin
      if (i == cut) begin
        push_pulse(1'b0, short_width());
        push_pulse(1'b0, long_width());
        break;
      end
      b = can_short() ? 1'($urandom_range(0, 1)) : ~lvl;
      if (b != lvl) begin
        push_pulse(1'b0, long_width());
      end else begin
        push_pulse(1'b0, short_width());
        push_pulse(1'b0, short_width());
      end
      lvl = b;
    end
    if (kind == MSG_GAP_END || kind == MSG_EARLY_GAP) push_pulse(1'b0, gap_width());
    add_noise($urandom_range(0, 3));
  endtask

  // all words sent, all bytes seen, then room for a run still in flight
  task automatic settle();
    while (pending_pulses.size() != 0 || in_valid) @(posedge clk_i);
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e r, input logic [WidthW-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    case (r)
      CFG_MIN_WIDTH:  model_cfg.min_width  = v;
      CFG_LONG_WIDTH: model_cfg.long_width = v;
      CFG_MAX_WIDTH:  model_cfg.max_width  = v;
      default:        model_cfg.preamble_min = v[PreW-1:0];
    endcase
  endtask

  task automatic set_thresholds(input logic [WidthW-1:0] lo_w, input logic [WidthW-1:0] long_w,
                                input logic [WidthW-1:0] hi_w, input logic [PreW-1:0] pre);
    write_reg(CFG_MIN_WIDTH, lo_w);
    write_reg(CFG_LONG_WIDTH, long_w);
    write_reg(CFG_MAX_WIDTH, hi_w);
    write_reg(CFG_PREAMBLE_MIN, {8'd0, pre});
    cfg_valid <= 1'b0;
    cfg_phases++;
  endtask

  // ---------------------------------------------------------------------------
  // pulse driver

  int          send_gap   = 0;
  int          send_burst = 0;
  pulse_word_t next_pulse;

  function automatic int sender_gap();
    int r;
    if (send_burst > 0) begin
      send_burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      send_burst = 40;
      return 0;
    end
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  always @(posedge clk_i) begin
    if (in_valid && in_if.ready === 1'b1) begin
      decode_pulse(in_word);
      pulses_sent++;
    end
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_if.ready === 1'b1) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_pulses.size() != 0) begin
        next_pulse = pending_pulses.pop_front();
        in_valid   <= 1'b1;
        in_word    <= next_pulse;
        send_gap   = sender_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // byte monitor and receiver stalls

  int        recv_stall    = 0;
  int        recv_burst    = 0;
  logic      pressure_done = 1'b0;
  int        recv_roll;
  msg_byte_t want;

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid === 1'b1 && out_ready) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected byte: expected none, actual data %h index %0d last %0b",
                 $time, out_if.data_byte, out_if.byte_index, out_if.last);
        errors++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_if.data_byte !== want.data) begin
          $display("%0t: data_byte mismatch: expected %h actual %h",
                   $time, want.data, out_if.data_byte);
          errors++;
        end
        if (out_if.byte_index !== want.idx) begin
          $display("%0t: byte_index mismatch: expected %0d actual %0d",
                   $time, want.idx, out_if.byte_index);
          errors++;
        end
        if (out_if.last !== want.last) begin
          $display("%0t: last mismatch: expected %0b actual %0b",
                   $time, want.last, out_if.last);
          errors++;
        end
      end
      results_seen++;
    end

    // one long hold-off at the start of a byte run while pulses are still queued,
    // else random stalls
    if (recv_stall > 0) begin
      recv_stall--;
      out_ready <= 1'b0;
    end else if (!pressure_done && results_seen >= 5 && pending_pulses.size() > 20 &&
                 out_if.valid === 1'b1 && out_if.byte_index == '0) begin
      pressure_done = 1'b1;
      recv_stall    = PressureCycles - 1;
      out_ready     <= 1'b0;
    end else if (recv_burst > 0) begin
      recv_burst--;
      out_ready <= 1'b1;
    end else begin
      recv_roll = $urandom_range(0, 99);
      if (recv_roll < 3) begin
        recv_burst = 80;
        out_ready  <= 1'b1;
      end else if (recv_roll < 25) begin
        recv_stall = (recv_roll < 22) ? $urandom_range(0, 2) : $urandom_range(8, 60);
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d bytes still awaited",
             CycleLimit, expected_bytes.size());
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // test sequence

  initial begin
    clear_decoder_model();
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    // threshold edges at reset values, restarts, errors while hunting
    push_pulse(1'b1, 16'hFFFF);
    push_pulse(1'b0, 16'd0);
    push_pulse(1'b0, 16'd199);
    push_pulse(1'b0, 16'd200);
    push_pulse(1'b0, 16'd699);
    push_pulse(1'b0, 16'd700);
    push_pulse(1'b0, 16'd200);
    push_pulse(1'b0, 16'd1199);
    push_pulse(1'b0, 16'd1200);
    push_pulse(1'b0, 16'hFFFF);
    push_pulse(1'b1, 16'h0000);
    add_message();
    settle();

    // narrow window with a short preamble
    set_thresholds(16'd100, 16'd400, 16'd900, 8'd2);
    repeat (2) add_message();
    settle();

    // widest window, no preamble needed
    set_thresholds(16'd0, 16'h8000, 16'hFFFF, 8'd0);
    add_message();
    add_noise(10);
    settle();

    // empty window: every pulse is a gap
    set_thresholds(16'hFFFF, 16'd0, 16'd0, PreSat);
    add_noise(30);
    settle();

    // every symbol long, so data bits alternate
    set_thresholds(16'd10, 16'd0, 16'd300, 8'd0);
    repeat (2) add_message();
    settle();

    // longest preamble, count saturates
    set_thresholds(16'd300, 16'd1000, 16'hFFFF, PreSat);
    add_message();
    settle();

    // no long symbol possible
    set_thresholds(16'd0, 16'hFFFF, 16'hFFFF, 8'd0);
    add_noise(30);
    settle();

    // moderate setting until enough bytes have been checked
    set_thresholds(16'd150, 16'd500, 16'd1000, 8'd8);
    while (bytes_predicted < BytesWanted && pulses_queued < ItemCap) begin
      repeat (2) add_message();
      settle();
    end

    $display("sent %0d pulse words under %0d threshold settings, widest to empty",
             pulses_sent, cfg_phases);
    $display("%0d messages decoded, %0d bytes checked, long receiver hold-off %s",
             messages_done, results_seen, pressure_done ? "applied" : "not reached");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/omd_pkg.sv
rtl/omd_if.sv
rtl/omd_store.sv
rtl/omd_ctrl.sv
rtl/ook_manchester_pulse_decoder.sv
tb/sv/testbench.sv
